/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tone mapping block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle, cons must hold in that same cycle
`define TMO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds in a cycle, cons must hold in the next one
`define TMO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// ante holds in a cycle, cons must hold dly cycles later
`define TMO_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

/* rtl/tmo_pkg.sv */
// ----------------------------------------------------------------------------
// tmo_pkg
// Types, constants and elaboration-time tables for the HDR tone mapper.
// ----------------------------------------------------------------------------
package tmo_pkg;

	localparam int FRAC_BITS = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPOSURE   = 3'd0,
		REG_WB_RED     = 3'd1,
		REG_WB_GREEN   = 3'd2,
		REG_WB_BLUE    = 3'd3,
		REG_TONE_CURVE = 3'd4,
		REG_GAMMA_EN   = 3'd5,
		REG_IGAMMA     = 3'd6,
		REG_CLAMP_EN   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CURVE_LINEAR   = 2'd0,
		CURVE_REINHARD = 2'd1,
		CURVE_FILMIC   = 2'd2,
		CURVE_ACES     = 2'd3
	} curve_t;

	// settings shared by all lanes
	typedef struct packed {
		logic [23:0] exposure_gain;
		curve_t      tone_curve;
		logic        gamma_enable;
		logic [22:0] inverse_gamma;
		logic        clamp_enable;
	} cfg_t;

	// reset values
	localparam logic [23:0] EXPOSURE_RST = 24'd65536;
	localparam logic [25:0] WB_RST       = 26'd65536;
	localparam logic [22:0] IGAMMA_RST   = 23'd29789;

	// pipeline sizing
	localparam int DIV_QB    = 20;  // quotient bits of the curve divider
	localparam int LOG_STEPS = 16;
	localparam int EXP_STEPS = 16;
	// gain(2) + curve setup(2) + divider + scale(1) + reciprocal(1) + select(1)
	// + normalize(1) + squaring + log(1) + exponent(1) + roots + shift(1) + quant(1)
	localparam int LANE_LAT = 2 + 2 + DIV_QB + 1 + 1 + 1 + 1 + LOG_STEPS
		+ 1 + 1 + EXP_STEPS + 1 + 1;
	localparam int LAT_CYCLES = LANE_LAT + 1;

	// tone curve constants
	localparam logic [23:0] VMAX     = 24'hFFFFFF;
	localparam logic [35:0] FIL_NB   = 36'd16384000;   // 250 << 16
	localparam logic [31:0] FIL_DB   = 32'd32768000;   // 500 << 16
	localparam logic [35:0] ACES_NB  = 36'd196608;     // 3 << 16
	localparam logic [31:0] ACES_DB  = 32'd3866624;    // 59 << 16
	localparam logic [56:0] FIL_K    = 57'd257698037760; // 60 << 32
	localparam logic [56:0] ACES_K   = 57'd60129542144;  // 14 << 32
	localparam logic [32:0] FIL_MUL  = 33'd6119;
	// ceil(2^46 / 16639): floor(n / 66556) = (n[32:2] * FIL_RECIP) >> 46 for 33-bit n
	localparam logic [31:0] FIL_RECIP = 32'(((64'd1 << 46) + 64'd16638) / 64'd16639);

	// floor square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = n;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-j) in Q.30 as a chain of floor square roots from one half
	function automatic logic [30:0] exp_root(input int j);
		logic [63:0] t;
		t = 64'd1 << 29;
		for (int i = 1; i <= EXP_STEPS; i++) begin
			if (i <= j) begin
				t = isqrt64(t << 30);
			end
		end
		return t[30:0];
	endfunction

endpackage

/* rtl/tmo_lane.sv */
// ----------------------------------------------------------------------------
// tmo_lane
// One color channel: gains, tone curve, gamma and 8-bit quantization,
// fully pipelined at one value per clock.
// ----------------------------------------------------------------------------
module tmo_lane (
	input  logic          clk,
	input  logic [31:0]   x,
	input  logic [25:0]   wb_gain,
	input  tmo_pkg::cfg_t cfg,
	output logic [7:0]    y
);

	localparam int DQ  = tmo_pkg::DIV_QB;
	localparam int LS  = tmo_pkg::LOG_STEPS;
	localparam int ES  = tmo_pkg::EXP_STEPS;

	logic [55:0] p1_w;
	logic [31:0] a_s1;
	logic [57:0] p2_w;
	logic [31:0] c_s2;

	logic [23:0] v_w;
	logic [35:0] nf_w;
	logic [31:0] df_w;
	logic [23:0] v_s3;
	logic [35:0] nf_s3;
	logic [31:0] df_s3;
	logic [31:0] c_s3;

	logic [59:0] num_w;
	logic [55:0] dprod_w;
	logic [56:0] dsum_w;

	logic [63:0] dv_rem_s [0:DQ];
	logic [40:0] dv_den_s [0:DQ];
	logic [DQ-1:0] dv_q_s [0:DQ];
	logic [31:0] dv_c_s [0:DQ];

	logic [32:0] mq_sm;
	logic [DQ-1:0] q_sm;
	logic [31:0] c_sm;

	logic [62:0] rq_w;
	logic [16:0] fq_sd;
	logic [DQ-1:0] q_sd;
	logic [31:0] c_sd;

	logic        ge1_w;
	logic [15:0] y16_w;
	logic        ge1_sy;
	logic [15:0] y16_sy;

	logic [3:0]  msb_w;
	logic [30:0] m_sn;
	logic [3:0]  p_sn;
	logic [15:0] y16_sn;
	logic        ge1_sn;

	logic [30:0] lg_m_s [0:LS];
	logic [15:0] lg_f_s [0:LS];
	logic [3:0]  lg_p_s [0:LS];
	logic [15:0] lg_y_s [0:LS];
	logic        lg_g_s [0:LS];

	logic [20:0] l_sl;
	logic [15:0] y16_sl;
	logic        ge1_sl;

	logic [43:0] up_w;
	logic [27:0] u_su;
	logic [15:0] y16_su;
	logic        ge1_su;

	logic [30:0] ex_r_s [0:ES];
	logic [27:0] ex_u_s [0:ES];
	logic [15:0] ex_y_s [0:ES];
	logic        ex_g_s [0:ES];

	logic [30:0] rs_sh;
	logic [15:0] y16_sh;
	logic        ge1_sh;

	logic [38:0] eq_w;
	logic [23:0] gq_w;
	logic [7:0]  y_sq;

	// exposure gain, saturate at the Q16.16 maximum
	assign p1_w = 56'(x) * 56'(cfg.exposure_gain);

	always_ff @(posedge clk) begin
		a_s1 <= (p1_w[55:48] != '0) ? '1 : p1_w[47:16];
	end

	// white balance gain, saturate
	assign p2_w = 58'(a_s1) * 58'(wb_gain);

	always_ff @(posedge clk) begin
		c_s2 <= (p2_w[57:48] != '0) ? '1 : p2_w[47:16];
	end

	// linear factors of the rational curves
	always_comb begin
		v_w = (c_s2[31:24] != '0) ? tmo_pkg::VMAX : c_s2[23:0];
		case (cfg.tone_curve)
			tmo_pkg::CURVE_FILMIC: begin
				nf_w = 36'(v_w) * 36'd2100 + tmo_pkg::FIL_NB;
				df_w = 32'(v_w) * 32'd150 + tmo_pkg::FIL_DB;
			end
			tmo_pkg::CURVE_ACES: begin
				nf_w = 36'(v_w) * 36'd251 + tmo_pkg::ACES_NB;
				df_w = 32'(v_w) * 32'd243 + tmo_pkg::ACES_DB;
			end
			default: begin
				nf_w = '0;
				df_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		v_s3  <= v_w;
		nf_s3 <= nf_w;
		df_s3 <= df_w;
		c_s3  <= c_s2;
	end

	// numerator and denominator of the curve
	assign num_w   = 60'(v_s3) * 60'(nf_s3);
	assign dprod_w = 56'(v_s3) * 56'(df_s3);
	assign dsum_w  = 57'(dprod_w)
		+ ((cfg.tone_curve == tmo_pkg::CURVE_FILMIC) ? tmo_pkg::FIL_K : tmo_pkg::ACES_K);

	always_ff @(posedge clk) begin
		dv_q_s[0] <= '0;
		dv_c_s[0] <= c_s3;
		if (cfg.tone_curve == tmo_pkg::CURVE_FILMIC || cfg.tone_curve == tmo_pkg::CURVE_ACES)
		begin
			dv_rem_s[0] <= 64'(num_w);
			dv_den_s[0] <= dsum_w[56:16];
		end else begin
			dv_rem_s[0] <= {16'b0, c_s3, 16'b0};
			dv_den_s[0] <= 41'(c_s3) + 41'd65536;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < DQ; i++) begin : g_div
		logic [63:0] sh_w;
		logic        ge_w;
		assign sh_w = 64'(dv_den_s[i]) << (DQ - 1 - i);
		assign ge_w = (dv_rem_s[i] >= sh_w);
		always_ff @(posedge clk) begin
			dv_rem_s[i+1] <= ge_w ? dv_rem_s[i] - sh_w : dv_rem_s[i];
			dv_den_s[i+1] <= dv_den_s[i];
			dv_q_s[i+1]   <= dv_q_s[i] | (DQ'(ge_w) << (DQ - 1 - i));
			dv_c_s[i+1]   <= dv_c_s[i];
		end
	end

	// filmic white scale numerator
	always_ff @(posedge clk) begin
		mq_sm <= 33'(dv_q_s[DQ]) * tmo_pkg::FIL_MUL;
		q_sm  <= dv_q_s[DQ];
		c_sm  <= dv_c_s[DQ];
	end

	// divide by the constant white scale through its reciprocal
	assign rq_w = 63'(mq_sm[32:2]) * 63'(tmo_pkg::FIL_RECIP);

	always_ff @(posedge clk) begin
		fq_sd <= rq_w[62:46];
		q_sd  <= q_sm;
		c_sd  <= c_sm;
	end

	// pick the curve output and flag values at or above one
	always_comb begin
		case (cfg.tone_curve)
			tmo_pkg::CURVE_LINEAR: begin
				ge1_w = (c_sd[31:16] != '0);
				y16_w = c_sd[15:0];
			end
			tmo_pkg::CURVE_FILMIC: begin
				ge1_w = fq_sd[16];
				y16_w = fq_sd[15:0];
			end
			default: begin
				ge1_w = (q_sd[DQ-1:16] != '0);
				y16_w = q_sd[15:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ge1_sy <= ge1_w;
		y16_sy <= y16_w;
	end

	// normalize to a Q.30 mantissa in one..two
	always_comb begin
		msb_w = '0;
		for (int i = 0; i < 16; i++) begin
			if (y16_sy[i]) begin
				msb_w = 4'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		m_sn   <= 31'(y16_sy) << (5'd30 - 5'(msb_w));
		p_sn   <= msb_w;
		y16_sn <= y16_sy;
		ge1_sn <= ge1_sy;
	end

	assign lg_m_s[0] = m_sn;
	assign lg_f_s[0] = '0;
	assign lg_p_s[0] = p_sn;
	assign lg_y_s[0] = y16_sn;
	assign lg_g_s[0] = ge1_sn;

	// log2 fraction, one squaring per stage
	for (genvar s = 0; s < LS; s++) begin : g_log
		logic [61:0] sq_w;
		assign sq_w = 62'(lg_m_s[s]) * 62'(lg_m_s[s]);
		always_ff @(posedge clk) begin
			if (sq_w[61]) begin
				lg_m_s[s+1] <= sq_w[61:31];
				lg_f_s[s+1] <= lg_f_s[s] | (16'd1 << (LS - 1 - s));
			end else begin
				lg_m_s[s+1] <= sq_w[60:30];
				lg_f_s[s+1] <= lg_f_s[s];
			end
			lg_p_s[s+1] <= lg_p_s[s];
			lg_y_s[s+1] <= lg_y_s[s];
			lg_g_s[s+1] <= lg_g_s[s];
		end
	end

	// negated log2 in Q.16
	always_ff @(posedge clk) begin
		l_sl   <= {5'd16 - 5'(lg_p_s[LS]), 16'b0} - 21'(lg_f_s[LS]);
		y16_sl <= lg_y_s[LS];
		ge1_sl <= lg_g_s[LS];
	end

	// scale by the inverse gamma
	assign up_w = 44'(cfg.inverse_gamma) * 44'(l_sl);

	always_ff @(posedge clk) begin
		u_su   <= up_w[43:16];
		y16_su <= y16_sl;
		ge1_su <= ge1_sl;
	end

	assign ex_r_s[0] = 31'd1 << 30;
	assign ex_u_s[0] = u_su;
	assign ex_y_s[0] = y16_su;
	assign ex_g_s[0] = ge1_su;

	// fractional power of two, one root factor per stage
	for (genvar s = 0; s < ES; s++) begin : g_exp
		localparam logic [30:0] ROOT = tmo_pkg::exp_root(s + 1);
		logic [61:0] pr_w;
		assign pr_w = 62'(ex_r_s[s]) * 62'(ROOT);
		always_ff @(posedge clk) begin
			ex_r_s[s+1] <= ex_u_s[s][ES - 1 - s] ? pr_w[60:30] : ex_r_s[s];
			ex_u_s[s+1] <= ex_u_s[s];
			ex_y_s[s+1] <= ex_y_s[s];
			ex_g_s[s+1] <= ex_g_s[s];
		end
	end

	// integer part of the exponent
	always_ff @(posedge clk) begin
		rs_sh  <= (ex_u_s[ES][27:16] >= 12'd31) ? '0 : ex_r_s[ES] >> ex_u_s[ES][20:16];
		y16_sh <= ex_y_s[ES];
		ge1_sh <= ex_g_s[ES];
	end

	// quantize to eight bits
	assign eq_w = 39'(rs_sh) * 39'd255 + 39'd536870912;
	assign gq_w = 24'(y16_sh) * 24'd255 + 24'd32768;

	always_ff @(posedge clk) begin
		if (ge1_sh) begin
			// at or above one the quantizer saturates with or without the clamp
			y_sq <= cfg.clamp_enable ? 8'd255 : 8'hFF;
		end else if (!cfg.gamma_enable) begin
			y_sq <= gq_w[23:16];
		end else if (y16_sh == '0) begin
			y_sq <= (cfg.inverse_gamma == '0) ? 8'd255 : 8'd0;
		end else begin
			y_sq <= eq_w[37:30];
		end
	end

	assign y = y_sq;

endmodule

/* rtl/hdr_tonemap_to_ldr.sv */
// ----------------------------------------------------------------------------
// hdr_tonemap_to_ldr
// HDR Q16.16 RGB pixel to 8-bit display RGB: exposure and white balance,
// tone curve, gamma and rounding, three channel lanes in parallel.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  pixel in  red_in, green_in, blue_in               start & !busy
//  pixel out red_out, green_out, blue_out            done, one cycle
//  config    cfg_idx, cfg_data                       cfg_we
//
//  One pixel is taken every clock; busy never rises.
//  Each result passes through the per-lane pipeline of curve divider,
//  log2 squaring chain and exp2 root chain, then the output registers.
//  Reset clears the settings to their defaults and drops pixels in flight.
//  The receiver cannot stall; done marks each result for one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdr_tonemap_to_ldr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [31:0]                      red_in,
	input  logic [31:0]                      green_in,
	input  logic [31:0]                      blue_in,
	output logic                             done,
	output logic [7:0]                       red_out,
	output logic [7:0]                       green_out,
	output logic [7:0]                       blue_out,
	input  logic                             cfg_we,
	input  logic [tmo_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tmo_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LAT = tmo_pkg::LANE_LAT;

	tmo_pkg::cfg_t cfg_q;
	logic [25:0]   wb_red_q;
	logic [25:0]   wb_green_q;
	logic [25:0]   wb_blue_q;

	logic [LAT-1:0] vld_q;
	logic           done_q;
	logic [7:0]     red_q;
	logic [7:0]     green_q;
	logic [7:0]     blue_q;
	logic [7:0]     red_w;
	logic [7:0]     green_w;
	logic [7:0]     blue_w;
	logic           accept_w;

	assign busy     = 1'b0;
	assign accept_w = start & ~busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exposure_gain <= tmo_pkg::EXPOSURE_RST;
			cfg_q.tone_curve    <= tmo_pkg::CURVE_LINEAR;
			cfg_q.gamma_enable  <= 1'b1;
			cfg_q.inverse_gamma <= tmo_pkg::IGAMMA_RST;
			cfg_q.clamp_enable  <= 1'b1;
			wb_red_q            <= tmo_pkg::WB_RST;
			wb_green_q          <= tmo_pkg::WB_RST;
			wb_blue_q           <= tmo_pkg::WB_RST;
		end else if (cfg_we) begin
			case (tmo_pkg::reg_idx_t'(cfg_idx))
				tmo_pkg::REG_EXPOSURE:   cfg_q.exposure_gain <= cfg_data[23:0];
				tmo_pkg::REG_WB_RED:     wb_red_q <= cfg_data;
				tmo_pkg::REG_WB_GREEN:   wb_green_q <= cfg_data;
				tmo_pkg::REG_WB_BLUE:    wb_blue_q <= cfg_data;
				tmo_pkg::REG_TONE_CURVE: cfg_q.tone_curve <= tmo_pkg::curve_t'(cfg_data[1:0]);
				tmo_pkg::REG_GAMMA_EN:   cfg_q.gamma_enable <= cfg_data[0];
				tmo_pkg::REG_IGAMMA:     cfg_q.inverse_gamma <= cfg_data[22:0];
				tmo_pkg::REG_CLAMP_EN:   cfg_q.clamp_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// channel lanes
	tmo_lane u_lane_red (
		.clk     (clk),
		.x       (red_in),
		.wb_gain (wb_red_q),
		.cfg     (cfg_q),
		.y       (red_w)
	);

	tmo_lane u_lane_green (
		.clk     (clk),
		.x       (green_in),
		.wb_gain (wb_green_q),
		.cfg     (cfg_q),
		.y       (green_w)
	);

	tmo_lane u_lane_blue (
		.clk     (clk),
		.x       (blue_in),
		.wb_gain (wb_blue_q),
		.cfg     (cfg_q),
		.y       (blue_w)
	);

	// track transactions through the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[LAT-2:0], accept_w};
			done_q <= vld_q[LAT-1];
		end
	end

	// merge the lanes into one result
	always_ff @(posedge clk) begin
		red_q   <= red_w;
		green_q <= green_w;
		blue_q  <= blue_w;
	end

	assign done      = done_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

	`TMO_ASSERT_DLY(a_latency, clk, arst_n, accept_w, tmo_pkg::LAT_CYCLES, done, "pixel result missing")
	`TMO_ASSERT_NXT(a_curve_wr, clk, arst_n, cfg_we && cfg_idx == tmo_pkg::REG_TONE_CURVE, cfg_q.tone_curve == $past(cfg_data[1:0]), "tone curve write lost")
	`TMO_ASSERT_NXT(a_igam_wr, clk, arst_n, cfg_we && cfg_idx == tmo_pkg::REG_IGAMMA, cfg_q.inverse_gamma == $past(cfg_data[22:0]), "inverse gamma write lost")

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hdr_tonemap_to_ldr. Pixels are driven through the
// start/busy command port under a series of register settings. Each accepted
// pixel is predicted in fixed point by a scoreboard, and every done strobe is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int           HALF_HI    = 6;
	localparam int           HALF_LO    = 6;
	localparam int           N_PIXELS   = 1850;
	localparam int           N_PHASES   = 18;
	localparam bit [63:0]    SAT32      = 64'hFFFF_FFFF;
	localparam bit [63:0]    ONE_Q16    = 64'd65536;

	typedef struct {
		bit [7:0] r;
		bit [7:0] g;
		bit [7:0] b;
	} ldr_pixel_t;

	// fixed point model of the tone mapper plus the queue of pending pixels
	class pixel_scoreboard;
		bit [23:0]        exposure;
		bit [25:0]        wb [3];
		tmo_pkg::curve_t  curve;
		bit               gamma_on;
		bit [22:0]        igamma;
		bit               clamp_on;
		bit [63:0]        root_q30 [17];
		ldr_pixel_t       expected_pixels [$];

		function new();
			bit [63:0] t;
			exposure  = tmo_pkg::EXPOSURE_RST;
			wb[0]     = tmo_pkg::WB_RST;
			wb[1]     = tmo_pkg::WB_RST;
			wb[2]     = tmo_pkg::WB_RST;
			curve     = tmo_pkg::CURVE_LINEAR;
			gamma_on  = 1'b1;
			igamma    = tmo_pkg::IGAMMA_RST;
			clamp_on  = 1'b1;
			// 2^(-2^-j) in Q.30, each step a floor square root of the last
			t = 64'd1 << 29;
			for (int j = 1; j <= 16; j++) begin
				t = floor_sqrt(t << 30);
				root_q30[j] = t;
			end
		endfunction

		static function bit [63:0] floor_sqrt(bit [63:0] n);
			bit [63:0] r;
			bit [63:0] cand;
			r = 0;
			for (int i = 31; i >= 0; i--) begin
				cand = r | (64'd1 << i);
				if (cand * cand <= n)
					r = cand;
			end
			return r;
		endfunction

		function void set_reg(tmo_pkg::reg_idx_t idx, bit [25:0] val);
			case (idx)
				tmo_pkg::REG_EXPOSURE:   exposure = val[23:0];
				tmo_pkg::REG_WB_RED:     wb[0] = val;
				tmo_pkg::REG_WB_GREEN:   wb[1] = val;
				tmo_pkg::REG_WB_BLUE:    wb[2] = val;
				tmo_pkg::REG_TONE_CURVE: curve = tmo_pkg::curve_t'(val[1:0]);
				tmo_pkg::REG_GAMMA_EN:   gamma_on = val[0];
				tmo_pkg::REG_IGAMMA:     igamma = val[22:0];
				tmo_pkg::REG_CLAMP_EN:   clamp_on = val[0];
				default: ;
			endcase
		endfunction

		static function bit [63:0] gain_sat(bit [63:0] a, bit [63:0] g);
			bit [63:0] p;
			p = (a * g) >> 16;
			return (p > SAT32) ? SAT32 : p;
		endfunction

		function bit [63:0] apply_curve(bit [63:0] c);
			bit [63:0] v;
			bit [63:0] num;
			bit [63:0] den;
			v = (c > 64'hFF_FFFF) ? 64'hFF_FFFF : c;
			case (curve)
				tmo_pkg::CURVE_REINHARD: return (c << 16) / (c + ONE_Q16);
				tmo_pkg::CURVE_FILMIC: begin
					num = v * (2100 * v + 250 * ONE_Q16);
					den = (v * (150 * v + 500 * ONE_Q16) + 60 * (ONE_Q16 << 16)) >> 16;
					return (num / den) * 6119 / 66556;
				end
				tmo_pkg::CURVE_ACES: begin
					num = v * (251 * v + 3 * ONE_Q16);
					den = (v * (243 * v + 59 * ONE_Q16) + 14 * (ONE_Q16 << 16)) >> 16;
					return num / den;
				end
				default: return c;
			endcase
		endfunction

		// -log2(y) in Q.16 for 0 < y < 1
		static function bit [63:0] minus_log2(bit [63:0] y);
			int        msb;
			bit [63:0] m;
			bit [63:0] frac;
			msb  = 0;
			frac = 0;
			while (msb < 15 && (y >> (msb + 1)) != 0)
				msb++;
			m = y << (30 - msb);
			for (int i = 1; i <= 16; i++) begin
				m = (m * m) >> 30;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					frac |= 64'd1 << (16 - i);
				end
			end
			return (16 - msb) * ONE_Q16 - frac;
		endfunction

		function bit [7:0] pow_to_byte(bit [63:0] u);
			bit [63:0] whole;
			bit [63:0] r;
			whole = u >> 16;
			if (whole >= 31)
				return 8'd0;
			r = 64'd1 << 30;
			for (int j = 1; j <= 16; j++)
				if (u[16 - j])
					r = (r * root_q30[j]) >> 30;
			r = r >> whole;
			return 8'((r * 255 + (64'd1 << 29)) >> 30);
		endfunction

		function bit [7:0] map_channel(bit [31:0] x, bit [25:0] g);
			bit [63:0] y;
			y = apply_curve(gain_sat(gain_sat(x, exposure), g));
			if (y >= ONE_Q16)
				return 8'd255;
			if (!gamma_on)
				return 8'((y * 255 + (ONE_Q16 >> 1)) >> 16);
			if (y == 0)
				return (igamma == 0) ? 8'd255 : 8'd0;
			return pow_to_byte((igamma * minus_log2(y)) >> 16);
		endfunction

		function void note_pixel(bit [31:0] r, bit [31:0] g, bit [31:0] b);
			ldr_pixel_t p;
			p.r = map_channel(r, wb[0]);
			p.g = map_channel(g, wb[1]);
			p.b = map_channel(b, wb[2]);
			expected_pixels.push_back(p);
		endfunction

		// append one line per fault to faults
		function void check_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b,
				ref string faults[$]);
			ldr_pixel_t p;
			if (expected_pixels.size() == 0) begin
				faults.push_back($sformatf("unexpected result %0d/%0d/%0d", r, g, b));
				return;
			end
			p = expected_pixels.pop_front();
			if (r !== p.r)
				faults.push_back($sformatf("red_out %0d, expected %0d", r, p.r));
			if (g !== p.g)
				faults.push_back($sformatf("green_out %0d, expected %0d", g, p.g));
			if (b !== p.b)
				faults.push_back($sformatf("blue_out %0d, expected %0d", b, p.b));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [31:0]                    red_in;
	logic [31:0]                    green_in;
	logic [31:0]                    blue_in;
	logic                           done;
	logic [7:0]                     red_out;
	logic [7:0]                     green_out;
	logic [7:0]                     blue_out;
	logic                           cfg_we;
	logic [tmo_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [tmo_pkg::CFG_DATA_W-1:0] cfg_data;

	pixel_scoreboard sb;
	int              mismatches;
	int              pixels_sent;

	hdr_tonemap_to_ldr dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#HALF_LO clk = 1'b1;
		#HALF_HI clk = 1'b0;
	end

	// bound the run
	initial begin
		#(12 * 300000);
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// note accepted pixels and check each result transaction
	always @(posedge clk) begin
		string faults [$];
		faults.delete();
		if (arst_n) begin
			if (start && !busy)
				sb.note_pixel(red_in, green_in, blue_in);
			if (done) begin
				sb.check_pixel(red_out, green_out, blue_out, faults);
				foreach (faults[i])
					report(faults[i]);
			end
		end
	end

	task automatic write_reg(tmo_pkg::reg_idx_t idx, bit [25:0] val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(bit [23:0] expo, bit [25:0] wr, bit [25:0] wg, bit [25:0] wbl,
			tmo_pkg::curve_t crv, bit gam, bit [22:0] ig, bit clmp);
		write_reg(tmo_pkg::REG_EXPOSURE, 26'(expo));
		write_reg(tmo_pkg::REG_WB_RED, wr);
		write_reg(tmo_pkg::REG_WB_GREEN, wg);
		write_reg(tmo_pkg::REG_WB_BLUE, wbl);
		write_reg(tmo_pkg::REG_TONE_CURVE, 26'(crv));
		write_reg(tmo_pkg::REG_GAMMA_EN, 26'(gam));
		write_reg(tmo_pkg::REG_IGAMMA, 26'(ig));
		write_reg(tmo_pkg::REG_CLAMP_EN, 26'(clmp));
	endtask

	// hold off until every pending pixel has come back, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (tmo_pkg::LAT_CYCLES + 4) @(posedge clk);
	endtask

	task automatic send_pixel(bit [31:0] r, bit [31:0] g, bit [31:0] b);
		int idle_pct;
		if (pixels_sent < N_PIXELS / 3)
			idle_pct = 28;
		else if (pixels_sent < 2 * N_PIXELS / 3)
			idle_pct = 56;
		else
			idle_pct = 0;
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start    = 1'b1;
		red_in   = r;
		green_in = g;
		blue_in  = b;
		do
			@(posedge clk);
		while (busy);
		pixels_sent++;
	endtask

	// log-spread value: mostly small, sometimes zero, sometimes every bit random
	function automatic bit [31:0] hdr_value();
		return 32'(64'($urandom) >> $urandom_range(32, 0));
	endfunction

	function automatic bit [25:0] gain_value(int bits);
		case ($urandom_range(9, 0))
			0:       return 26'd0;
			1:       return 26'((64'd1 << bits) - 1);
			2, 3, 4: return 26'(ONE_Q16 + $urandom_range(65536, 0) - 32768);
			default: return 26'((64'($urandom) & ((64'd1 << bits) - 1))
				>> $urandom_range(bits - 1, 0));
		endcase
	endfunction

	function automatic bit [22:0] igamma_value();
		case ($urandom_range(7, 0))
			0:       return 23'd0;
			1:       return 23'd6553600;
			2:       return tmo_pkg::IGAMMA_RST;
			default: return 23'($urandom_range(3 * 65536, 1));
		endcase
	endfunction

	task automatic send_directed();
		send_pixel(32'd0, 32'd0, 32'd0);
		send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(32'h0001_0000, 32'h0000_FFFF, 32'd1);
		send_pixel(32'h0000_8000, 32'h0000_4000, 32'h0000_0100);
		send_pixel(32'h8000_0000, 32'h000B_3333, 32'h5555_AAAA);
	endtask

	initial begin
		int n_rand;
		sb          = new();
		mismatches  = 0;
		pixels_sent = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		cfg_we      = 1'b0;
		cfg_idx     = tmo_pkg::REG_EXPOSURE;
		cfg_data    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings first, then each curve and the extremes
		send_directed();
		drain();
		write_all(24'h01_0000, 26'h1_0000, 26'h1_0000, 26'h1_0000, tmo_pkg::CURVE_REINHARD,
			1'b1, tmo_pkg::IGAMMA_RST, 1'b1);
		send_directed();
		drain();
		write_all(24'h02_0000, 26'h1_0000, 26'h0_8000, 26'h2_0000, tmo_pkg::CURVE_FILMIC,
			1'b0, tmo_pkg::IGAMMA_RST, 1'b0);
		send_directed();
		drain();
		write_all(24'h01_0000, 26'h1_0000, 26'h1_0000, 26'h1_0000, tmo_pkg::CURVE_ACES,
			1'b1, 23'd0, 1'b1);
		send_directed();
		drain();
		write_all(24'hFF_FFFF, 26'h3FF_FFFF, 26'h3FF_FFFF, 26'h3FF_FFFF, tmo_pkg::CURVE_LINEAR,
			1'b1, 23'd6553600, 1'b0);
		send_directed();
		drain();

		// random settings with random pixels
		n_rand = (N_PIXELS - pixels_sent) / N_PHASES;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_all(24'(gain_value(24)), gain_value(26), gain_value(26), gain_value(26),
				tmo_pkg::curve_t'($urandom_range(3, 0)), 1'($urandom), igamma_value(),
				1'($urandom));
			if (ph == N_PHASES - 1)
				write_reg(tmo_pkg::REG_EXPOSURE, 26'h0);
			for (int i = 0; i < n_rand; i++)
				send_pixel(hdr_value(), hdr_value(), hdr_value());
			drain();
		end

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
